FILE: hw/rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge package
// Shared types and constants for the streaming Sobel edge block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned PIX_W     = 3 * CHAN_W;
    localparam int unsigned FW_W      = 11;
    localparam int unsigned FH_W      = 13;
    localparam int unsigned ROW_W     = 13;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 13;
    localparam int unsigned HEIGHT_LIMIT = 4096;
    localparam logic [CHAN_W-1:0] SAT_LEVEL = 8'd255;
    // Squared magnitude: max gx, gy is 4*255 = 1020, so sum < 2^21
    localparam int unsigned SQ_W = 21;
    localparam int unsigned GRAD_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Neighbor mask and tags passed from front to back, per window
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic row_end;
        logic frame_end;
    } win_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] c0_top;
        logic [PIX_W-1:0] c0_mid;
        logic [PIX_W-1:0] c0_bot;
        logic [PIX_W-1:0] c1_top;
        logic [PIX_W-1:0] c1_bot;
        logic [PIX_W-1:0] c2_top;
        logic [PIX_W-1:0] c2_mid;
        logic [PIX_W-1:0] c2_bot;
        win_ctl_t         ctl;
    } win_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              row_end;
        logic              frame_end;
    } edge_res_t;

endpackage

FILE: hw/rtl/sobel_if.sv
// ----------------------------------------------------------------------------
// Sobel stream interfaces
// Valid/ready channels for pixel input and edge output.
// ----------------------------------------------------------------------------
interface sobel_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic       flush;
    modport source (output valid, pixel_blue, pixel_green, pixel_red, flush, input ready);
    modport sink   (input valid, pixel_blue, pixel_green, pixel_red, flush, output ready);
endinterface

interface sobel_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_blue;
    logic [7:0] edge_green;
    logic [7:0] edge_red;
    logic       row_end;
    logic       frame_end;
    modport source (output valid, edge_blue, edge_green, edge_red, row_end, frame_end,
                    input ready);
    modport sink   (input valid, edge_blue, edge_green, edge_red, row_end, frame_end,
                    output ready);
endinterface

FILE: hw/rtl/sobel_front.sv
// ----------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, tracks frame position, keeps two line stores and the
// 3x3 window, and issues a window with its edge mask for each result.
// ----------------------------------------------------------------------------
module sobel_front #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [sobel_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sobel_pkg::PIX_W-1:0]     in_pix,
    input  logic                            in_flush,
    output logic                            win_valid,
    input  logic                            win_ready,
    output sobel_pkg::win_t                 win
);
    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);

    logic [sobel_pkg::FW_W-1:0] fw_reg;
    logic [sobel_pkg::FH_W-1:0] fh_reg;
    logic [WCNT_W-1:0]          used_w;
    logic [sobel_pkg::ROW_W:0]  used_h;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [sobel_pkg::ROW_W-1:0] row_reg, row_next;

    // Clamp registers to their legal ranges
    always_comb
    begin
        if (fw_reg == '0)
            used_w = WCNT_W'(1);
        else if ({21'd0, fw_reg} > 32'(MAX_WIDTH))
            used_w = WCNT_W'(MAX_WIDTH);
        else
            used_w = WCNT_W'(fw_reg);
        if (fh_reg == '0)
            used_h = (sobel_pkg::ROW_W+1)'(1);
        else if ({19'd0, fh_reg} > 32'(sobel_pkg::HEIGHT_LIMIT))
            used_h = (sobel_pkg::ROW_W+1)'(sobel_pkg::HEIGHT_LIMIT);
        else
            used_h = (sobel_pkg::ROW_W+1)'(fh_reg);
    end

    // Stage 1: read line stores; stage 2: window shift
    logic [sobel_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [sobel_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic                        s1_valid_reg;
    logic [sobel_pkg::PIX_W-1:0] s1_pix_reg;
    logic                        s1_emit_reg;
    sobel_pkg::win_ctl_t         s1_ctl_reg;
    logic [sobel_pkg::PIX_W-1:0] top_rd_reg, mid_rd_reg;

    logic                        out_valid_reg;
    logic [sobel_pkg::PIX_W-1:0] w_reg [9];
    sobel_pkg::win_ctl_t         out_ctl_reg;

    logic accept, adv, emit, last_col, last_frame;
    logic [sobel_pkg::PIX_W-1:0] v;
    logic [COL_W-1:0]            cc;
    logic [sobel_pkg::ROW_W-1:0] rc;
    sobel_pkg::win_ctl_t         ctl;

    // Window register can move when the consumer takes it or it holds nothing
    assign adv      = ~out_valid_reg | win_ready;
    assign in_ready = adv;
    assign accept   = in_valid & in_ready;

    // Position bookkeeping and edge mask for the pixel being accepted
    always_comb
    begin
        v = ((~in_flush) && ({1'b0, row_reg} < used_h)) ? in_pix : '0;
        emit = (row_reg >= sobel_pkg::ROW_W'(2)) ||
               (row_reg == sobel_pkg::ROW_W'(1) && col_reg != '0);
        if (col_reg != '0)
        begin
            cc = col_reg - COL_W'(1);
            rc = row_reg - sobel_pkg::ROW_W'(1);
        end
        else
        begin
            cc = COL_W'(used_w - WCNT_W'(1));
            rc = row_reg - sobel_pkg::ROW_W'(2);
        end
        last_col   = (WCNT_W'(cc) + WCNT_W'(1)) >= used_w;
        last_frame = last_col && (({1'b0, rc} + 1'b1) >= used_h);
        ctl.top_ok    = (rc != '0);
        ctl.bot_ok    = (({1'b0, rc} + 1'b1) < used_h);
        ctl.left_ok   = (cc != '0);
        ctl.right_ok  = ~last_col;
        ctl.row_end   = last_col;
        ctl.frame_end = last_frame;
        if (emit && last_frame)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if ((WCNT_W'(col_reg) + WCNT_W'(1)) >= used_w)
        begin
            col_next = '0;
            row_next = row_reg + sobel_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // Configuration and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= sobel_pkg::FW_W'(640);
            fh_reg  <= sobel_pkg::FH_W'(480);
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we && (cfg_idx == sobel_pkg::REG_FRAME_WIDTH ||
                            cfg_idx == sobel_pkg::REG_FRAME_HEIGHT))
        begin
            if (cfg_idx == sobel_pkg::REG_FRAME_WIDTH)
                fw_reg <= cfg_data[sobel_pkg::FW_W-1:0];
            else
                fh_reg <= cfg_data[sobel_pkg::FH_W-1:0];
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores: read old entry and write new one at the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg <= upper_mem[col_reg];
            mid_rd_reg <= middle_mem[col_reg];
            upper_mem[col_reg]  <= middle_mem[col_reg];
            middle_mem[col_reg] <= v;
            s1_pix_reg <= v;
            s1_ctl_reg <= ctl;
            s1_emit_reg <= emit;
        end
    end

    // A same-column pair of accepts is at least one row apart, so the
    // store read above never races a write of the previous cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept;
    end

    // Window shift and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                w_reg[i] <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg & s1_emit_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    w_reg[r*3]   <= w_reg[r*3+1];
                    w_reg[r*3+1] <= w_reg[r*3+2];
                end
                w_reg[2] <= top_rd_reg;
                w_reg[5] <= mid_rd_reg;
                w_reg[8] <= s1_pix_reg;
                out_ctl_reg <= s1_ctl_reg;
            end
        end
    end

    assign win_valid   = out_valid_reg;
    assign win.c0_top  = w_reg[0];
    assign win.c1_top  = w_reg[1];
    assign win.c2_top  = w_reg[2];
    assign win.c0_mid  = w_reg[3];
    assign win.c2_mid  = w_reg[5];
    assign win.c0_bot  = w_reg[6];
    assign win.c1_bot  = w_reg[7];
    assign win.c2_bot  = w_reg[8];
    assign win.ctl     = out_ctl_reg;
endmodule

FILE: hw/rtl/sobel_queue.sv
// ----------------------------------------------------------------------------
// Sobel window queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module sobel_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  sobel_pkg::win_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output sobel_pkg::win_t rd_data
);
    sobel_pkg::win_t mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic            push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: hw/rtl/sobel_back.sv
// ----------------------------------------------------------------------------
// Sobel back end
// Gradient, squared magnitude and rounded integer square root, pipelined
// one square-root bit per stage, with an output register.
// ----------------------------------------------------------------------------
module sobel_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sobel_pkg::win_t       win,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sobel_pkg::edge_res_t  res
);
    localparam int unsigned NST = 8;
    localparam int unsigned SW  = sobel_pkg::SQ_W;
    localparam int unsigned GW  = sobel_pkg::GRAD_W;

    // gradient, square sum, root seed, eight root bits, rounding register
    logic adv;
    logic [NST+3:0] v_reg;
    sobel_pkg::win_ctl_t ctl_reg [NST+4];

    assign adv      = ~v_reg[NST+3] | out_ready;
    assign in_ready = adv;

    // Masked pixel value
    function automatic logic signed [GW-1:0] px(input logic [sobel_pkg::PIX_W-1:0] p,
                                                input int ch, input logic ok);
        logic [7:0] c;
        c = p[ch*8 +: 8];
        return ok ? GW'($signed({3'b000, c})) : '0;
    endfunction

    logic signed [GW-1:0] gx_reg [3], gy_reg [3];
    logic [SW-1:0]        sq_reg [3];
    logic [7:0]           n_reg [NST+1][3];
    logic [SW-1:0]        s_reg [NST+1][3];
    logic [7:0]           mag_reg [3];
    sobel_pkg::win_ctl_t  k;

    assign k = win.ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST+2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= k;
            for (int i = 1; i < NST+4; i++)
                ctl_reg[i] <= ctl_reg[i-1];
            for (int ch = 0; ch < 3; ch++)
            begin
                // Stage 0: gradients
                gx_reg[ch] <= px(win.c2_top, ch, k.top_ok & k.right_ok)
                            - px(win.c0_top, ch, k.top_ok & k.left_ok)
                            + (px(win.c2_mid, ch, k.right_ok) <<< 1)
                            - (px(win.c0_mid, ch, k.left_ok) <<< 1)
                            + px(win.c2_bot, ch, k.bot_ok & k.right_ok)
                            - px(win.c0_bot, ch, k.bot_ok & k.left_ok);
                gy_reg[ch] <= px(win.c0_bot, ch, k.bot_ok & k.left_ok)
                            + (px(win.c1_bot, ch, k.bot_ok) <<< 1)
                            + px(win.c2_bot, ch, k.bot_ok & k.right_ok)
                            - px(win.c0_top, ch, k.top_ok & k.left_ok)
                            - (px(win.c1_top, ch, k.top_ok) <<< 1)
                            - px(win.c2_top, ch, k.top_ok & k.right_ok);
                // Stage 1: sum of squares, then the root seed
                sq_reg[ch] <= SW'(gx_reg[ch] * gx_reg[ch]) + SW'(gy_reg[ch] * gy_reg[ch]);
                n_reg[0][ch] <= '0;
                s_reg[0][ch] <= sq_reg[ch];
                // Root stages after the seed: one root bit per stage
                for (int b = 0; b < NST; b++)
                begin
                    logic [7:0] t;
                    t = n_reg[b][ch] | (8'h80 >> b);
                    n_reg[b+1][ch] <= ({8'd0, t} * {8'd0, t} <= 16'(s_reg[b][ch]) &&
                                       s_reg[b][ch] < SW'(65536)) ||
                                      (s_reg[b][ch] >= SW'(65536)) ? t : n_reg[b][ch];
                    s_reg[b+1][ch] <= s_reg[b][ch];
                end
                // Final: round and saturate
                if (s_reg[NST][ch] > SW'(65280))
                    mag_reg[ch] <= sobel_pkg::SAT_LEVEL;
                else if (s_reg[NST][ch] > SW'({8'd0, n_reg[NST][ch]} * {8'd0, n_reg[NST][ch]})
                                          + SW'(n_reg[NST][ch]))
                    mag_reg[ch] <= n_reg[NST][ch] + 8'd1;
                else
                    mag_reg[ch] <= n_reg[NST][ch];
            end
        end
    end

    assign out_valid     = v_reg[NST+3];
    assign res.blue      = mag_reg[0];
    assign res.green     = mag_reg[1];
    assign res.red       = mag_reg[2];
    assign res.row_end   = ctl_reg[NST+3].row_end;
    assign res.frame_end = ctl_reg[NST+3].frame_end;
endmodule

FILE: hw/rtl/sobel_edge_magnitude_rgb_top.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel gradient magnitude per color channel.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  pix       in         pixel_blue/green/red, flush
//  res       out        edge_blue/green/red, row_end, frame_end
//  cfg       in         cfg_we, cfg_idx, cfg_data (width, height)
//
// One pixel per clock sustained while the result side does not stall.
// A result passes the line-store stage, window register, queue and back end.
// Reset needs no clearing pass; line stores are masked at frame edges.
// Either side may stall; the window queue decouples front and back.
module sobel_edge_magnitude_rgb_top #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [sobel_pkg::CFG_DAT_W-1:0] cfg_data,
    sobel_pix_if.sink                       pix,
    sobel_edge_if.source                    res
);
    logic            fw_valid, fw_ready, bk_valid, bk_ready;
    sobel_pkg::win_t fw_win, bk_win;
    sobel_pkg::edge_res_t r;

    sobel_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
        .in_valid(pix.valid), .in_ready(pix.ready),
        .in_pix({pix.pixel_red, pix.pixel_green, pix.pixel_blue}),
        .in_flush(pix.flush),
        .win_valid(fw_valid), .win_ready(fw_ready), .win(fw_win)
    );

    sobel_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fw_valid), .wr_ready(fw_ready), .wr_data(fw_win),
        .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_data(bk_win)
    );

    sobel_back u_back (
        .clk, .rst_n,
        .in_valid(bk_valid), .in_ready(bk_ready), .win(bk_win),
        .out_valid(res.valid), .out_ready(res.ready), .res(r)
    );

    assign res.edge_blue  = r.blue;
    assign res.edge_green = r.green;
    assign res.edge_red   = r.red;
    assign res.row_end    = r.row_end;
    assign res.frame_end  = r.frame_end;
endmodule

FILE: hw/rtl/sobel_checker.sv
// ----------------------------------------------------------------------------
// Sobel port checker
// Port-level properties of the Sobel edge block.
// ----------------------------------------------------------------------------
module sobel_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_row_end,
    input logic       res_frame_end,
    input logic [7:0] res_blue
);
    // A frame end is always a row end
    a_fe_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res_frame_end || res_row_end)) else $error("frame_end w/o row_end");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_blue))
        else $error("result dropped under stall");

    // Nothing comes out right after reset
    a_rst: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("valid after reset");
endmodule

bind sobel_edge_magnitude_rgb_top sobel_checker u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res.valid), .res_ready(res.ready),
    .res_row_end(res.row_end), .res_frame_end(res.frame_end), .res_blue(res.edge_blue)
);

FILE: bench/sobel_edge_checker.sv
// ----------------------------------------------------------------------------
// Sobel edge checker
// Watches the config port and both stream channels, predicts each edge
// result from the accepted pixels and compares every result field by field.
// ----------------------------------------------------------------------------
module sobel_edge_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [sobel_pkg::CFG_DAT_W-1:0] cfg_data,
    sobel_pix_if                            pix,
    sobel_edge_if                           res,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_DEPTH = 1024;

    logic [sobel_pkg::PIX_W-1:0] upper_line [LINE_DEPTH];
    logic [sobel_pkg::PIX_W-1:0] middle_line [LINE_DEPTH];
    logic [sobel_pkg::PIX_W-1:0] window [9];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    logic [sobel_pkg::FW_W-1:0]  width_reg;
    logic [sobel_pkg::FH_W-1:0]  height_reg;
    sobel_pkg::edge_res_t        edge_q [$];

    // nearest integer square root, saturated at 255
    function automatic logic [sobel_pkg::CHAN_W-1:0] rounded_root(int unsigned s);
        int unsigned n;
        int unsigned t;
        n = 0;
        if (s > 255 * 255 + 255)
            return sobel_pkg::SAT_LEVEL;
        for (int b = 7; b >= 0; b--)
        begin
            t = n | (1 << b);
            if (t * t <= s)
                n = t;
        end
        if (s > n * n + n)
            n++;
        return (n > 255) ? sobel_pkg::SAT_LEVEL : n[sobel_pkg::CHAN_W-1:0];
    endfunction

    // Sobel magnitude of one color channel over the masked window
    function automatic logic [sobel_pkg::CHAN_W-1:0] channel_mag(int shift, bit ok [9]);
        int gx;
        int gy;
        int p;
        int kx [9];
        int ky [9];
        gx = 0;
        gy = 0;
        kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
        ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
        for (int i = 0; i < 9; i++)
        begin
            if (ok[i])
            begin
                p = (window[i] >> shift) & 8'hFF;
                gx += p * kx[i];
                gy += p * ky[i];
            end
        end
        return rounded_root(gx * gx + gy * gy);
    endfunction

    // advance the window by one accepted transaction, queue any result
    task automatic take_pixel(bit fl, logic [sobel_pkg::PIX_W-1:0] pixel);
        int unsigned w;
        int unsigned h;
        int unsigned ic;
        int unsigned ir;
        int unsigned rc;
        int unsigned cc;
        logic [sobel_pkg::PIX_W-1:0] v;
        logic [sobel_pkg::PIX_W-1:0] top;
        logic [sobel_pkg::PIX_W-1:0] mid;
        bit ok [9];
        bit rok;
        bit cok;
        sobel_pkg::edge_res_t e;
        w  = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
        h  = (height_reg == 0) ? 1 :
             (height_reg > sobel_pkg::HEIGHT_LIMIT) ? sobel_pkg::HEIGHT_LIMIT : height_reg;
        ic = (col_pos < w) ? col_pos : 0;
        ir = row_pos;
        v  = (!fl && ir < h) ? pixel : '0;
        top = upper_line[ic];
        mid = middle_line[ic];
        upper_line[ic]  = mid;
        middle_line[ic] = v;
        for (int r = 0; r < 3; r++)
        begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = v;

        if (!(ir >= 2 || (ir == 1 && ic >= 1)))
        begin
            ic++;
            if (ic >= w)
            begin
                ic = 0;
                ir++;
            end
            col_pos = ic;
            row_pos = ir;
            return;
        end

        // center of the completed window lags one row plus one pixel
        if (ic >= 1)
        begin
            cc = ic - 1;
            rc = ir - 1;
        end
        else
        begin
            cc = w - 1;
            rc = ir - 2;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rok = !((r == 0 && rc == 0) || (r == 2 && rc + 1 >= h));
                cok = !((c == 0 && cc == 0) || (c == 2 && cc + 1 >= w));
                ok[r*3+c] = rok && cok;
            end
        end
        e.blue      = channel_mag(0, ok);
        e.green     = channel_mag(8, ok);
        e.red       = channel_mag(16, ok);
        e.row_end   = (cc + 1 >= w);
        e.frame_end = e.row_end && (rc + 1 >= h);
        edge_q.push_back(e);

        if (e.frame_end)
        begin
            ic = 0;
            ir = 0;
        end
        else
        begin
            ic++;
            if (ic >= w)
            begin
                ic = 0;
                ir++;
            end
        end
        col_pos = ic;
        row_pos = ir;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sobel_pkg::edge_res_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                window[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = 11'd640;
            height_reg = 13'd480;
            errors     = 0;
            edge_q.delete();
        end
        else
        begin
            // register write restarts the frame position
            if (cfg_we)
            begin
                if (cfg_idx == sobel_pkg::REG_FRAME_WIDTH)
                    width_reg = cfg_data[sobel_pkg::FW_W-1:0];
                else
                    height_reg = cfg_data[sobel_pkg::FH_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            if (pix.valid && pix.ready)
                take_pixel(pix.flush, {pix.pixel_red, pix.pixel_green, pix.pixel_blue});
            if (res.valid && res.ready)
            begin
                if (edge_q.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errors++;
                end
                else
                begin
                    e = edge_q.pop_front();
                    if (res.edge_blue !== e.blue)
                    begin
                        $error("edge_blue: expected %0d, actual %0d", e.blue, res.edge_blue);
                        errors++;
                    end
                    if (res.edge_green !== e.green)
                    begin
                        $error("edge_green: expected %0d, actual %0d", e.green, res.edge_green);
                        errors++;
                    end
                    if (res.edge_red !== e.red)
                    begin
                        $error("edge_red: expected %0d, actual %0d", e.red, res.edge_red);
                        errors++;
                    end
                    if (res.row_end !== e.row_end)
                    begin
                        $error("row_end: expected %0d, actual %0d", e.row_end, res.row_end);
                        errors++;
                    end
                    if (res.frame_end !== e.frame_end)
                    begin
                        $error("frame_end: expected %0d, actual %0d",
                               e.frame_end, res.frame_end);
                        errors++;
                    end
                end
            end
        end
        pending = edge_q.size();
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Sobel edge testbench
// Drives frames of RGB pixels with flush drains through the edge block,
// with random idling on both sides, and lets the checker judge each result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sobel_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [sobel_pkg::CFG_DAT_W-1:0] cfg_data;
    int                              errors;
    int                              pending;
    int                              sent_items;
    bit                              steady;
    bit                              held;

    sobel_pix_if  pix_ch ();
    sobel_edge_if res_ch ();

    sobel_edge_magnitude_rgb_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .pix      (pix_ch),
        .res      (res_ch)
    );

    sobel_edge_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .pix      (pix_ch),
        .res      (res_ch),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // stretch of transactions with no idling on either side
    assign steady = (sent_items >= 300 && sent_items < 500);

    // receiver: random stalls, plus one long hold-off to back up the block
    initial
    begin
        res_ch.ready = 1'b0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sent_items >= 5)
            begin
                held = 1;
                res_ch.ready = 1'b0;
                repeat (200) @(negedge clk);
            end
            res_ch.ready = steady || ($urandom_range(99) >= 9);
        end
    end

    function automatic logic [7:0] pick_chan(int mode);
        case (mode)
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            2: return 8'd255;
            default: return 8'd0;
        endcase
    endfunction

    // one pixel transaction; called at a falling edge, returns at one
    task automatic send_item(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit fl);
        while (!steady && $urandom_range(99) < 9)
        begin
            pix_ch.valid = 1'b0;
            @(negedge clk);
        end
        pix_ch.valid       = 1'b1;
        pix_ch.pixel_blue  = b;
        pix_ch.pixel_green = g;
        pix_ch.pixel_red   = r;
        pix_ch.flush       = fl;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    // wait until every expected result is out, then let the pipe go quiet
    task automatic settle();
        pix_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                             logic [sobel_pkg::CFG_DAT_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic configure(int raw_w, int raw_h);
        settle();
        // upper data bits fall outside the width register
        write_reg(sobel_pkg::REG_FRAME_WIDTH, {2'($urandom_range(3)), 11'(raw_w)});
        write_reg(sobel_pkg::REG_FRAME_HEIGHT, 13'(raw_h));
    endtask

    // one frame plus its drain; noisy mixes in flushes, pixel drains, aborts
    task automatic run_frame(int raw_w, int raw_h, int mode, bit noisy, output bit aborted);
        int w;
        int h;
        int abort_at;
        bit fl;
        w = (raw_w == 0) ? 1 : (raw_w > 1024) ? 1024 : raw_w;
        h = (raw_h == 0) ? 1 :
            (raw_h > sobel_pkg::HEIGHT_LIMIT) ? sobel_pkg::HEIGHT_LIMIT : raw_h;
        abort_at = (noisy && $urandom_range(7) == 0) ? $urandom_range(w * h - 1) : -1;
        aborted = 0;
        for (int p = 0; p < w * h; p++)
        begin
            fl = noisy && ($urandom_range(99) < 5);
            send_item(pick_chan(mode), pick_chan(mode), pick_chan(mode), fl);
            if (p == abort_at)
            begin
                aborted = 1;
                return;
            end
        end
        for (int k = 0; k <= w; k++)
        begin
            fl = !(noisy && $urandom_range(1));
            send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), fl);
        end
    endtask

    initial
    begin
        int w;
        int h;
        int reps;
        bit aborted;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_blue  = '0;
        pix_ch.pixel_green = '0;
        pix_ch.pixel_red   = '0;
        pix_ch.flush       = 1'b0;
        sent_items         = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed frames: flat, binary and degenerate sizes
        configure(3, 3);
        run_frame(3, 3, 2, 0, aborted);
        run_frame(3, 3, 3, 0, aborted);
        run_frame(3, 3, 1, 0, aborted);
        configure(0, 0);
        run_frame(0, 0, 2, 0, aborted);
        configure(1, 3);
        run_frame(1, 3, 1, 1, aborted);
        configure(4, 1);
        run_frame(4, 1, 0, 0, aborted);

        // random frames, mostly small
        while (sent_items < 700)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            configure(w, h);
            reps = $urandom_range(3, 1);
            for (int i = 0; i < reps; i++)
            begin
                run_frame(w, h, $urandom_range(1), $urandom_range(3) == 0, aborted);
                if (aborted)
                    break;
            end
        end

        settle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("FAIL");
        $finish;
    end

endmodule
